/* src/max_pool_2d_macros.svh */
// assertion macros shared by the max pooling block
`ifndef MAX_POOL_2D_MACROS_SVH
`define MAX_POOL_2D_MACROS_SVH

// condition must hold at every clock edge out of reset
`define MP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("max_pool_2d: invariant violated");

// antecedent implies consequent in the same cycle
`define MP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_pool_2d: same-cycle implication violated");

// antecedent implies consequent in the next cycle
`define MP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_pool_2d: next-cycle implication violated");

`endif

/* src/mpool_pkg.sv */
// types, constants and register indices of the max pooling block
package mpool_pkg;

    // sizing of the block
    localparam int MAX_MAP_WIDTH = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_WINDOW    = 16;
    localparam int MAX_CHANNELS  = 1024;
    localparam int MAX_HEIGHT    = 1024;

    // register field widths
    localparam int DIM_W = 11;
    localparam int WIN_W = 5;
    localparam int CFG_IDX_W = 3;

    // counter widths
    localparam int POS_W  = $clog2(MAX_MAP_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CHAN_W = $clog2(MAX_CHANNELS);
    localparam int OFF_W  = $clog2(MAX_WINDOW);

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // divider step counter
    localparam int DIV_CNT_W = $clog2(DIM_W + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 3'd0,
        CFG_MAP_HEIGHT    = 3'd1,
        CFG_MAP_WIDTH     = 3'd2,
        CFG_WINDOW_ROWS   = 3'd3,
        CFG_WINDOW_COLS   = 3'd4
    } t_cfg_index;

    // divider result: quotient and the part of the dividend it covers
    typedef struct packed {
        logic [DIM_W-1:0] quotient;
        logic [DIM_W-1:0] whole;
    } t_div_res;

endpackage

/* src/mpool_div.sv */
// restoring divider of a map dimension by a window size, one bit per cycle
module mpool_div
    import mpool_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIM_W-1:0] i_dividend,
    input  logic [WIN_W-1:0] i_divisor,
    output logic             o_busy,
    output t_div_res         o_res
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_acc;
    logic [WIN_W-1:0]     r_rem;
    logic [WIN_W-1:0]     r_div;
    logic [DIM_W-1:0]     r_num;
    t_div_res             r_res;

    logic [WIN_W:0]   trial;
    logic             take;
    logic [WIN_W-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_acc[DIM_W-1]};
        take  = trial >= {1'b0, r_div};
        n_rem = take ? WIN_W'(trial - {1'b0, r_div}) : WIN_W'(trial);
    end

    // sequencing and result capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_res  <= '{quotient: DIM_W'(1), whole: DIM_W'(2)};
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_acc  <= i_dividend;
            r_num  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (r_cnt == DIV_CNT_W'(DIM_W)) begin
                r_busy         <= 1'b0;
                r_res.quotient <= r_acc;
                r_res.whole    <= r_num - DIM_W'(r_rem);
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_rem <= n_rem;
                r_acc <= {r_acc[DIM_W-2:0], take};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

/* src/max_pool_2d.sv */
// streaming non-overlapping 2-d max pooling over a multi-channel feature map
//
//  channel   direction  handshake                        payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata sample, tuser frame_start
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata pooled, tlast frame_end
//  cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// one sample per cycle when nothing stalls the input; each sample reads the line store at
// acceptance, and one that ends a window row in whole windows writes back in the cycle after,
// with forwarding between the two. a result goes through the write-back stage to the output queue.
// after reset and after every register write the window divisions run on a bit-serial
// divider, and the input stalls until they finish.
// the output queue of four entries absorbs stalls on the result side; the line store
// needs no clearing pass.
module max_pool_2d
    import mpool_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input samples
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,  // [15:0] sample
    input  logic                   i_s_axis_tuser,  // [0] frame_start
    // pooled results
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [SAMPLE_BITS-1:0] o_m_axis_tdata,  // [15:0] pooled
    output logic                   o_m_axis_tlast,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data
);

`include "max_pool_2d_macros.svh"

    // configuration registers, held already clamped
    logic [DIM_W-1:0] r_chans, r_hgt, r_wid;
    logic [WIN_W-1:0] r_wr, r_wc;
    logic             r_recalc;

    // position state
    logic [POS_W-1:0]  r_col, r_ocol;
    logic [ROW_W-1:0]  r_row;
    logic [CHAN_W-1:0] r_chan;
    logic [OFF_W-1:0]  r_offc, r_offr;
    t_sample           r_rmax;

    // line store and its read port
    t_sample r_line [MAX_MAP_WIDTH];
    t_sample r_rd_data;

    // write-back stage
    logic             r_s1_valid, r_s1_emit, r_s1_last, r_s1_first, r_s1_fwd;
    logic [POS_W-1:0] r_s1_addr;
    t_sample          r_s1_rmax, r_s1_fwd_data;

    // output queue
    t_sample               r_fifo_data [FIFO_DEPTH];
    logic [FIFO_DEPTH-1:0] r_fifo_last;
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    // divider interface
    logic     div_start, div_busy, col_busy, row_busy;
    t_div_res col_res, row_res;

    logic in_accept, cfg_accept, out_pop;

    // clamp helpers for register writes
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
        logic [WIN_W-1:0] r;
        r = v;
        if (v == '0) r = WIN_W'(1);
        else if (v > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
        return r;
    endfunction

    // configuration port
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;
    assign div_busy    = col_busy | row_busy;
    assign div_start   = r_recalc & ~div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans  <= DIM_W'(1);
            r_hgt    <= DIM_W'(2);
            r_wid    <= DIM_W'(2);
            r_wr     <= WIN_W'(2);
            r_wc     <= WIN_W'(2);
            r_recalc <= 1'b1;
        end else begin
            if (div_start) r_recalc <= 1'b0;
            if (cfg_accept) begin
                r_recalc <= 1'b1;
                unique case (i_cfg_index)
                    CFG_CHANNEL_COUNT: r_chans <= clamp_dim(i_cfg_data, DIM_W'(MAX_CHANNELS));
                    CFG_MAP_HEIGHT:    r_hgt   <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                    CFG_MAP_WIDTH:     r_wid   <= clamp_dim(i_cfg_data, DIM_W'(MAX_MAP_WIDTH));
                    CFG_WINDOW_ROWS:   r_wr    <= clamp_win(i_cfg_data[WIN_W-1:0]);
                    CFG_WINDOW_COLS:   r_wc    <= clamp_win(i_cfg_data[WIN_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // window counts along columns and rows
    mpool_div u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_wid),
        .i_divisor  (r_wc),
        .o_busy     (col_busy),
        .o_res      (col_res)
    );

    mpool_div u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_hgt),
        .i_divisor  (r_wr),
        .o_busy     (row_busy),
        .o_res      (row_res)
    );

    // input handshake: room for everything in flight in the output queue
    logic [FIFO_CNT_W-1:0] pending;
    assign pending         = r_count + FIFO_CNT_W'(r_s1_emit);
    assign o_s_axis_tready = ~r_recalc & ~div_busy & (pending <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;

    // position decode for the incoming sample
    t_sample           s_in;
    logic [POS_W-1:0]  c_col, c_ocol;
    logic [ROW_W-1:0]  c_row;
    logic [CHAN_W-1:0] c_chan;
    logic [OFF_W-1:0]  c_offc, c_offr;
    logic              in_win, col_end, row_end, do_write, emit, last;
    t_sample           n_rmax;
    logic [POS_W-1:0]  n_col, n_ocol;
    logic [ROW_W-1:0]  n_row;
    logic [CHAN_W-1:0] n_chan;
    logic [OFF_W-1:0]  n_offc, n_offr;
    t_sample           s1_old, s1_m;

    always_comb begin
        s_in   = t_sample'(i_s_axis_tdata);
        c_col  = i_s_axis_tuser ? '0 : r_col;
        c_ocol = i_s_axis_tuser ? '0 : r_ocol;
        c_row  = i_s_axis_tuser ? '0 : r_row;
        c_chan = i_s_axis_tuser ? '0 : r_chan;
        c_offc = i_s_axis_tuser ? '0 : r_offc;
        c_offr = i_s_axis_tuser ? '0 : r_offr;

        in_win   = (DIM_W'(c_col) < col_res.whole) && (DIM_W'(c_row) < row_res.whole);
        col_end  = (WIN_W'(c_offc) + WIN_W'(1)) == r_wc;
        row_end  = (WIN_W'(c_offr) + WIN_W'(1)) == r_wr;
        do_write = in_win & col_end;
        emit     = do_write & row_end;
        last     = (DIM_W'(c_chan) + DIM_W'(1) == r_chans)
                && (DIM_W'(c_row) + DIM_W'(1) == row_res.whole)
                && (DIM_W'(c_ocol) + DIM_W'(1) == col_res.quotient);

        // running maximum along the window row
        n_rmax = r_rmax;
        if (in_win && (c_offc == '0 || s_in > r_rmax)) n_rmax = s_in;

        // advance positions
        n_row  = c_row;
        n_chan = c_chan;
        n_offr = c_offr;
        if ((WIN_W'(c_offc) + WIN_W'(1)) >= r_wc) begin
            n_offc = '0;
            n_ocol = c_ocol + 1'b1;
        end else begin
            n_offc = c_offc + 1'b1;
            n_ocol = c_ocol;
        end
        if ((DIM_W'(c_col) + DIM_W'(1)) >= r_wid) begin
            n_col  = '0;
            n_offc = '0;
            n_ocol = '0;
            n_offr = ((WIN_W'(c_offr) + WIN_W'(1)) >= r_wr) ? '0 : c_offr + 1'b1;
            if ((DIM_W'(c_row) + DIM_W'(1)) >= r_hgt) begin
                n_row  = '0;
                n_offr = '0;
                n_chan = ((DIM_W'(c_chan) + DIM_W'(1)) >= r_chans) ? '0 : c_chan + 1'b1;
            end else begin
                n_row = c_row + 1'b1;
            end
        end else begin
            n_col = c_col + 1'b1;
        end

        // merge with the partial maximum of the rows above
        s1_old = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
        s1_m   = (!r_s1_first && s1_old > r_s1_rmax) ? s1_old : r_s1_rmax;
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_ocol <= '0;
            r_row  <= '0;
            r_chan <= '0;
            r_offc <= '0;
            r_offr <= '0;
            r_rmax <= '0;
        end else if (in_accept) begin
            r_col  <= n_col;
            r_ocol <= n_ocol;
            r_row  <= n_row;
            r_chan <= n_chan;
            r_offc <= n_offc;
            r_offr <= n_offr;
            r_rmax <= n_rmax;
        end
    end

    // write-back stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            r_s1_valid <= in_accept & do_write;
            r_s1_emit  <= in_accept & emit;
        end
    end

    // write-back stage payload, forwarding a write to the entry being read
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr     <= c_ocol;
            r_s1_rmax     <= n_rmax;
            r_s1_first    <= (c_offr == '0);
            r_s1_last     <= last;
            r_s1_fwd      <= r_s1_valid && (r_s1_addr == c_ocol);
            r_s1_fwd_data <= s1_m;
        end
    end

    // line store: registered read at acceptance, write-back in the cycle after
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) r_line[r_s1_addr] <= s1_m;
        if (in_accept) r_rd_data <= r_line[c_ocol];
    end

    // output queue
    assign out_pop         = o_m_axis_tvalid & i_m_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = r_fifo_data[r_rd_ptr];
    assign o_m_axis_tlast  = r_fifo_last[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_s1_emit) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (out_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + FIFO_CNT_W'(r_s1_emit) - FIFO_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_emit) begin
            r_fifo_data[r_wr_ptr] <= s1_m;
            r_fifo_last[r_wr_ptr] <= r_s1_last;
        end
    end

    // checks on the block's own bookkeeping
    `MP_ASSERT_ALWAYS(a_queue_bound, r_count <= FIFO_CNT_W'(FIFO_DEPTH - 1))
    `MP_ASSERT_IMPL(a_no_accept_while_dividing, in_accept, !div_busy && !r_recalc)
    `MP_ASSERT_IMPL(a_emit_has_writeback, r_s1_emit, r_s1_valid)
    `MP_ASSERT_NEXT(a_cfg_triggers_recalc, cfg_accept, r_recalc && !o_s_axis_tready)

endmodule

/* tb/sv/max_pool_2d_checker.sv */
// checker for the max pooling block: predicts pooled results and compares them
module max_pool_2d_checker
    import mpool_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,  // [15:0] sample
    input  logic                   i_s_axis_tuser,  // [0] frame_start
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_m_axis_tdata,  // [15:0] pooled
    input  logic                   i_m_axis_tlast,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_sample pooled;
        logic    frame_end;
    } t_pooled_result;

    // results still owed by the block, oldest first
    t_pooled_result pooled_expected[$];
    t_pooled_result oldest;
    int             fail_total = 0;

    // shadow copies of the registers as written
    logic [DIM_W-1:0] channels_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_reg;
    logic [WIN_W-1:0] win_rows_reg;
    logic [WIN_W-1:0] win_cols_reg;

    // shadow pooling state
    t_sample           partial_max [MAX_MAP_WIDTH];
    t_sample           row_max;
    logic [POS_W-1:0]  col_pos;
    logic [POS_W-1:0]  out_col;
    logic [ROW_W-1:0]  row_pos;
    logic [CHAN_W-1:0] chan_pos;
    logic [OFF_W-1:0]  col_off;
    logic [OFF_W-1:0]  row_off;

    // zero reads as one, anything above the bound as the bound
    function automatic int unsigned effective_size(input int unsigned raw,
                                                   input int unsigned bound);
        if (raw == 0)
            return 1;
        if (raw > bound)
            return bound;
        return raw;
    endfunction

    // one accepted sample: update the window state, queue a result when a window closes
    task automatic predict_pooled(input t_sample value, input logic start);
        int unsigned    chans;
        int unsigned    hgt;
        int unsigned    wid;
        int unsigned    wr;
        int unsigned    wc;
        int unsigned    out_cols;
        int unsigned    whole_cols;
        int unsigned    whole_rows;
        t_sample        best;
        t_pooled_result item;
        chans      = effective_size(channels_reg, MAX_CHANNELS);
        hgt        = effective_size(height_reg, MAX_HEIGHT);
        wid        = effective_size(width_reg, MAX_MAP_WIDTH);
        wr         = effective_size(win_rows_reg, MAX_WINDOW);
        wc         = effective_size(win_cols_reg, MAX_WINDOW);
        out_cols   = wid / wc;
        whole_cols = out_cols * wc;
        whole_rows = (hgt / wr) * wr;

        // frame start clears every position before the sample counts
        if (start) begin
            col_pos  = '0;
            row_pos  = '0;
            chan_pos = '0;
            col_off  = '0;
            row_off  = '0;
            out_col  = '0;
        end

        // samples outside whole windows leave no trace
        if (col_pos < whole_cols && row_pos < whole_rows) begin
            if (col_off == 0 || value > row_max)
                row_max = value;
            if (col_off + 1 == wc && out_col < MAX_MAP_WIDTH) begin
                best = row_max;
                if (row_off != 0 && partial_max[out_col] > best)
                    best = partial_max[out_col];
                partial_max[out_col] = best;
                if (row_off + 1 == wr) begin
                    item.pooled    = best;
                    item.frame_end = (chan_pos + 1 == chans) && (row_pos + 1 == whole_rows)
                                     && (out_col + 1 == out_cols);
                    pooled_expected.push_back(item);
                end
            end
        end

        // step column, row and channel positions
        if (col_off + 1 >= wc) begin
            col_off = '0;
            out_col = out_col + 1'b1;
        end else begin
            col_off = col_off + 1'b1;
        end
        if (col_pos + 1 >= wid) begin
            col_pos = '0;
            col_off = '0;
            out_col = '0;
            if (row_off + 1 >= wr)
                row_off = '0;
            else
                row_off = row_off + 1'b1;
            if (row_pos + 1 >= hgt) begin
                row_pos = '0;
                row_off = '0;
                if (chan_pos + 1 >= chans)
                    chan_pos = '0;
                else
                    chan_pos = chan_pos + 1'b1;
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            channels_reg = 1;
            height_reg   = 2;
            width_reg    = 2;
            win_rows_reg = 2;
            win_cols_reg = 2;
            row_max      = '0;
            col_pos      = '0;
            row_pos      = '0;
            chan_pos     = '0;
            col_off      = '0;
            row_off      = '0;
            out_col      = '0;
            pooled_expected.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pooled_expected.size() == 0) begin
                    $error("pooled: no result expected, got %0d", $signed(i_m_axis_tdata));
                    fail_total++;
                end else begin
                    oldest = pooled_expected.pop_front();
                    if (oldest.pooled !== $signed(i_m_axis_tdata)) begin
                        $error("pooled: expected %0d, got %0d", oldest.pooled,
                               $signed(i_m_axis_tdata));
                        fail_total++;
                    end
                    if (oldest.frame_end !== i_m_axis_tlast) begin
                        $error("frame_end: expected %0d, got %0d", oldest.frame_end,
                               i_m_axis_tlast);
                        fail_total++;
                    end
                end
            end

            // register write transaction, window fields keep their low bits only
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHANNEL_COUNT: channels_reg = i_cfg_data;
                    CFG_MAP_HEIGHT:    height_reg   = i_cfg_data;
                    CFG_MAP_WIDTH:     width_reg    = i_cfg_data;
                    CFG_WINDOW_ROWS:   win_rows_reg = i_cfg_data[WIN_W-1:0];
                    CFG_WINDOW_COLS:   win_cols_reg = i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            // sample transaction
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_pooled(t_sample'(i_s_axis_tdata), i_s_axis_tuser);
        end
        o_fail_count <= fail_total;
        o_pending    <= pooled_expected.size();
    end

endmodule

/* tb/sv/tb_max_pool_2d.sv */
// testbench top for the max pooling block: stimulus, idling and the verdict
module tb_max_pool_2d
    import mpool_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      RUN_LIMIT        = 400000;
    localparam int      DRAIN_CYCLES     = 16;
    localparam int      LONG_HOLD_CYCLES = 300;
    localparam int      RANDOM_PHASES    = 8;
    localparam int      PHASE_ITEMS      = 16;
    localparam int      WIDE_MAP_WIDTH   = 32;
    localparam int      MANY_CHANNELS    = 16;
    localparam int      RESTART_PCT      = 3;
    localparam int      HEAVY_PCT        = 57;
    localparam int      SHARED_PCT       = 26;
    localparam int      UNMAPPED_FIRST   = int'(CFG_WINDOW_COLS) + 1;
    localparam int      UNMAPPED_LAST    = (1 << CFG_IDX_W) - 1;
    localparam int      DIM_ALL_ONES     = (1 << DIM_W) - 1;
    localparam t_sample SAMPLE_MAX       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [SAMPLE_BITS-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_req       = 1'b0;
    logic        hold_ack       = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    always #6 clk = ~clk;

    max_pool_2d i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    max_pool_2d_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // result side: random stalls, or one long hold-off when asked for
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;          recv_stall_pct = 0;          end
            IDLE_SENDER:   begin send_idle_pct = HEAVY_PCT;  recv_stall_pct = 0;          end
            IDLE_RECEIVER: begin send_idle_pct = 0;          recv_stall_pct = HEAVY_PCT;  end
            default:       begin send_idle_pct = SHARED_PCT; recv_stall_pct = SHARED_PCT; end
        endcase
    endtask

    // offer one sample and wait for its transaction
    task automatic push_sample(input t_sample value, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // new geometry once idle, with a stray write to an unmapped index first
    task automatic load_geometry(input int chans, input int hgt, input int wid,
                                 input int wr, input int wc);
        settle_block();
        write_reg(CFG_IDX_W'($urandom_range(UNMAPPED_LAST, UNMAPPED_FIRST)), DIM_W'($urandom));
        write_reg(CFG_CHANNEL_COUNT, DIM_W'(chans));
        write_reg(CFG_MAP_HEIGHT, DIM_W'(hgt));
        write_reg(CFG_MAP_WIDTH, DIM_W'(wid));
        write_reg(CFG_WINDOW_ROWS, DIM_W'(wr));
        write_reg(CFG_WINDOW_COLS, DIM_W'(wc));
        cfg_valid <= 1'b0;
    endtask

    // extremes often, otherwise any value
    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic int pick_dim(input int hi);
        if ($urandom_range(9) == 0)
            return 0;
        return $urandom_range(hi, 1);
    endfunction

    function automatic int pick_window();
        case ($urandom_range(19))
            0:       return 0;
            1:       return $urandom_range(MAX_WINDOW, 5);
            default: return $urandom_range(4, 1);
        endcase
    endfunction

    // a run of samples, the first opening a frame, later ones restarting now and then
    task automatic stream_samples(input int count, input int restart_pct);
        for (int k = 0; k < count; k++)
            push_sample(pick_sample(), (k == 0) || ($urandom_range(99) < restart_pct));
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        // reset geometry, one 2x2 window per frame, no frame start needed
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        // next frame follows after the wrap
        repeat (4) push_sample(SAMPLE_MIN, 1'b0);
        // frame start in the middle of a frame, all-negative window
        push_sample(16'sd100, 1'b0);
        push_sample(16'sd200, 1'b0);
        push_sample(-16'sd5, 1'b1);
        push_sample(-16'sd3, 1'b0);
        push_sample(-16'sd7, 1'b0);
        push_sample(-16'sd9, 1'b0);

        // zero registers act as one, so every sample is a window
        load_geometry(0, 0, 0, 0, 0);
        stream_samples(3, 0);
        // window larger than the map never yields
        load_geometry(1, 2, 2, 3, 3);
        stream_samples(4, 0);
        // trailing row and column outside whole windows
        load_geometry(1, 3, 5, 2, 2);
        stream_samples(15, 0);
        // oversized sizes clamp, window fields keep their low bits
        set_idling(IDLE_SENDER);
        load_geometry(DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES, 11'h7E1, 11'h7E2);
        stream_samples(20, 0);

        // wide map, one line store entry per column
        set_idling(IDLE_RECEIVER);
        load_geometry(1, 2, WIDE_MAP_WIDTH, 2, 1);
        stream_samples(2 * WIDE_MAP_WIDTH, 0);
        // largest window
        set_idling(IDLE_BOTH);
        load_geometry(1, MAX_WINDOW, MAX_WINDOW, MAX_WINDOW, MAX_WINDOW);
        stream_samples(MAX_WINDOW * MAX_WINDOW, 0);
        // many channels, wrapping into the next frame
        set_idling(IDLE_SENDER);
        load_geometry(MANY_CHANNELS, 1, 1, 1, 1);
        // long hold-off on the result side while samples keep coming
        hold_req <= ~hold_req;
        stream_samples(MANY_CHANNELS + 4, 0);

        // random geometries on small maps
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_idling(t_idle_mode'(p % 4));
            load_geometry(pick_dim(3), pick_dim(8), pick_dim(12), pick_window(), pick_window());
            stream_samples(PHASE_ITEMS, RESTART_PCT);
        end

        settle_block();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
